@@ rtl/medf3_pkg.sv @@
// Package for the 3x3 median filter: widths, register indexes, defaults,
// the sorted-column type and the compare helpers for the nine-value median.
// No dependencies.
package medf3_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_W_W    = 11;
	localparam int CFG_H_W    = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
	localparam logic [CFG_H_W-1:0] RST_FRAME_HEIGHT = 13'd1024;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column, sorted low to high
	typedef struct packed {
		pix_t hi;
		pix_t md;
		pix_t lo;
	} col_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
		col_t s;
		s.lo = min2(min2(a, b), c);
		s.md = med3(a, b, c);
		s.hi = max2(max2(a, b), c);
		return s;
	endfunction

	// median of nine from three sorted columns
	function automatic pix_t median9(input col_t a, input col_t b, input col_t c);
		pix_t lo_max;
		pix_t md_med;
		pix_t hi_min;
		lo_max = max2(max2(a.lo, b.lo), c.lo);
		md_med = med3(a.md, b.md, c.md);
		hi_min = min2(min2(a.hi, b.hi), c.hi);
		return med3(lo_max, md_med, hi_min);
	endfunction

endpackage

@@ rtl/median_filter_3x3_top.sv @@
// 3x3 median filter, zero padded, over a raster pixel stream with a drain row.
// Path: an accepted beat passes the stage 1 registers, the window and the output
// register; a row's last column gives a second result after the first.
// Throughput: one pixel per cycle while out_stall is low; a last column with two
// results stalls the input; the single output register takes one beat per cycle.
// Reset: counters, window, pipeline clear; registers load defaults; line store kept.
module median_filter_3x3_top import medf3_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      median,
	output logic                  frame_end,
	output logic                  step_last
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT + 1);
	localparam int WEXT = (CFG_W_W > $clog2(MAX_WIDTH + 1)) ? CFG_W_W : $clog2(MAX_WIDTH + 1);
	localparam int HEXT = (CFG_H_W > RW) ? CFG_H_W : RW;
	localparam int LW   = 2 * PIX_W;

	logic [CFG_W_W-1:0] frame_width_q;
	logic [CFG_H_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[CFG_W_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[CFG_H_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size
	logic [WEXT-1:0] w_ext, w_eff;
	logic [HEXT-1:0] h_ext, h_eff;
	logic [CW-1:0]   w_last;
	logic [RW-1:0]   h_lim;

	always_comb begin
		w_ext = WEXT'(frame_width_q);
		h_ext = HEXT'(frame_height_q);
		if (w_ext == '0)
			w_eff = WEXT'(1);
		else if (w_ext > WEXT'(MAX_WIDTH))
			w_eff = WEXT'(MAX_WIDTH);
		else
			w_eff = w_ext;
		if (h_ext == '0)
			h_eff = HEXT'(1);
		else if (h_ext > HEXT'(MAX_HEIGHT))
			h_eff = HEXT'(MAX_HEIGHT);
		else
			h_eff = h_ext;
		w_last = CW'(w_eff - WEXT'(1));
		h_lim  = RW'(h_eff);
	end

	// stage 0: position of the incoming beat
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_c;
	logic [RW-1:0] row_c;
	logic          drain_c, last_c, in_acc;
	pix_t          pix_c;
	logic          s1_ready;

	always_comb begin
		col_c   = (col_q > w_last) ? w_last : col_q;
		drain_c = (row_q >= h_lim);
		row_c   = drain_c ? h_lim : row_q;
		last_c  = (col_c == w_last);
		pix_c   = drain_c ? '0 : pixel;
	end

	assign in_stall = !s1_ready;
	assign in_acc   = in_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_c) begin
				col_q <= '0;
				row_q <= drain_c ? '0 : RW'(row_c + RW'(1));
			end else begin
				col_q <= CW'(col_c + CW'(1));
				row_q <= row_c;
			end
		end
	end

	// stage 1 registers
	logic          valid_s1;
	logic [CW-1:0] addr_s1;
	logic          c0_s1, r0_s1, last_s1, drain_s1;
	pix_t          pix_s1;

	// line store: {upper, middle} per column
	logic [LW-1:0] line_mem [MAX_WIDTH];
	logic [LW-1:0] rd_s1, fwd_data_s1, wr_data;
	logic          fwd_s1, wr_en;
	logic          s1_adv;

	assign s1_adv = valid_s1 && s1_ready;
	assign wr_en  = s1_adv;

	always_ff @(posedge clk) begin
		if (wr_en)
			line_mem[addr_s1] <= wr_data;
		if (in_acc) begin
			rd_s1       <= line_mem[col_c];
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
			if (in_valid)
				fwd_s1 <= wr_en && (addr_s1 == col_c);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1  <= col_c;
			c0_s1    <= (col_c == '0);
			r0_s1    <= (row_c == '0);
			last_s1  <= last_c;
			drain_s1 <= drain_c;
			pix_s1   <= pix_c;
		end
	end

	logic [LW-1:0] line_rd;
	pix_t          top_s1, mid_s1;
	col_t          new_col;

	always_comb begin
		line_rd = fwd_s1 ? fwd_data_s1 : rd_s1;
		top_s1  = line_rd[LW-1:PIX_W];
		mid_s1  = line_rd[PIX_W-1:0];
		wr_data = {(r0_s1 ? '0 : mid_s1), pix_s1};
		new_col = sort3(top_s1, mid_s1, pix_s1);
	end

	// window of sorted columns, index 2 newest
	col_t win_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (s1_adv) begin
			win_q[0] <= c0_s1 ? '0 : win_q[1];
			win_q[1] <= c0_s1 ? '0 : win_q[2];
			win_q[2] <= new_col;
		end
	end

	// stage 2: pending results of the item in the window
	logic pend_a_q, pend_b_q, drain_s2;
	logic out_free, emit, s2_take;
	pix_t med_a, med_b;

	assign med_a    = median9(win_q[0], win_q[1], win_q[2]);
	assign med_b    = median9(win_q[1], win_q[2], '0);
	assign out_free = !out_valid || !out_stall;
	assign emit     = out_free && (pend_a_q || pend_b_q);
	assign s2_take  = !(pend_a_q || pend_b_q) || (emit && (pend_a_q ^ pend_b_q));
	assign s1_ready = !valid_s1 || s2_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
		end else if (s1_adv) begin
			pend_a_q <= !r0_s1 && !c0_s1;
			pend_b_q <= !r0_s1 && last_s1;
		end else if (emit) begin
			if (pend_a_q)
				pend_a_q <= 1'b0;
			else
				pend_b_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			drain_s2 <= drain_s1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (emit)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			median    <= pend_a_q ? med_a : med_b;
			frame_end <= !pend_a_q && drain_s2;
			step_last <= !pend_a_q || !pend_b_q;
		end
	end

	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted beat missing from stage 1");

	a_s2_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && (pend_a_q || pend_b_q) |-> emit && !(pend_a_q && pend_b_q))
		else $error("window overwritten with results pending");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> step_last)
		else $error("frame end on a non-final beat");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for median_filter_3x3_top: directed frames, then random frames,
// checked beat by beat against a zero-padded 3x3 median predictor. Needs medf3_pkg.
module tb_top;
	import medf3_pkg::*;

	localparam int MAXW          = DEF_MAX_WIDTH;
	localparam int MAXH          = DEF_MAX_HEIGHT;
	localparam int RANDOM_ITEMS  = 780;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_CYCLES  = 8;
	localparam int SETTLE_LIMIT  = 2000;

	typedef struct packed {
		pix_t median;
		logic frame_end;
		logic step_last;
	} filt_out_t;

	localparam filt_out_t NO_BEAT = '0;

	typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_FINISH} row_kind_t;
	typedef enum logic [1:0] {FR_SMALL, FR_BUSY, FR_EXTREME} frame_mode_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   index;
		int                     value;
		int                     typed_n;
		filt_out_t              t0;
		filt_out_t              t1;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	pix_t                  pixel     = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	pix_t                  median;
	logic                  frame_end;
	logic                  step_last;

	median_filter_3x3_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.median    (median),
		.frame_end (frame_end),
		.step_last (step_last)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [CFG_W_W-1:0] width_reg  = RST_FRAME_WIDTH;
	logic [CFG_H_W-1:0] height_reg = RST_FRAME_HEIGHT;
	pix_t               upper_row [MAXW];
	pix_t               middle_row [MAXW];
	pix_t               nbhd [9] = '{default: '0};
	int                 col_at = 0;
	int                 row_at = 0;

	filt_out_t medians_due [$];
	stim_row_t stim_rows [$];
	filt_out_t due;
	int        mismatches  = 0;
	int        pixels_sent = 0;
	bit        tx_idle     = 1'b0;
	bit        rx_idle     = 1'b0;
	int        hold_req    = 0;
	int        hold_seen   = 0;
	int        stall_left  = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int clamp_dim(input int v, input int hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic pix_t median_of_nine(input pix_t v [9]);
		pix_t s [9];
		pix_t t;
		s = v;
		for (int i = 0; i < 9; i++)
			for (int j = 0; j < 8 - i; j++)
				if (s[j] > s[j+1]) begin
					t = s[j];
					s[j] = s[j+1];
					s[j+1] = t;
				end
		return s[4];
	endfunction

	function automatic void nbhd_shift(input pix_t top, input pix_t mid, input pix_t bot);
		pix_t col [3];
		col = '{top, mid, bot};
		for (int r = 0; r < 3; r++) begin
			nbhd[r*3]   = nbhd[r*3+1];
			nbhd[r*3+1] = nbhd[r*3+2];
			nbhd[r*3+2] = col[r];
		end
	endfunction

	// advances the predictor by one pixel; returns the number of output beats
	function automatic int filter_step(input pix_t px, output filt_out_t res [2]);
		int   w, h, c, r, n;
		bit   last_col, drain;
		pix_t p, top, mid;
		w = clamp_dim(width_reg, MAXW);
		h = clamp_dim(height_reg, MAXH);
		c = (col_at > w - 1) ? w - 1 : col_at;
		r = row_at;
		drain = (r >= h);
		if (drain)
			r = h;
		last_col = (c == w - 1);
		p = drain ? '0 : px;
		top = upper_row[c];
		mid = middle_row[c];
		upper_row[c] = (r == 0) ? '0 : mid;
		middle_row[c] = p;
		if (c == 0)
			nbhd = '{default: '0};
		nbhd_shift(top, mid, p);
		n = 0;
		res[0] = NO_BEAT;
		res[1] = NO_BEAT;
		if (r >= 1) begin
			if (c >= 1) begin
				res[0] = '{median: median_of_nine(nbhd), frame_end: 1'b0, step_last: !last_col};
				n = 1;
			end
			if (last_col) begin
				nbhd_shift('0, '0, '0);
				res[n] = '{median: median_of_nine(nbhd), frame_end: drain, step_last: 1'b1};
				n++;
			end
		end
		if (last_col) begin
			col_at = 0;
			row_at = drain ? 0 : r + 1;
		end else begin
			col_at = c + 1;
			row_at = r;
		end
		return n;
	endfunction

	function automatic pix_t pick_pixel();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_row(input row_kind_t kind, input logic [CFG_IDX_W-1:0] index,
			input int value, input int typed_n, input filt_out_t t0, input filt_out_t t1);
		stim_row_t row;
		row = '{kind: kind, index: index, value: value, typed_n: typed_n, t0: t0, t1: t1};
		stim_rows = {stim_rows, row};
	endfunction

	// lowers valid, waits out every pending beat, then lets the pipeline empty
	task automatic settle();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (medians_due.size() != 0 && guard < SETTLE_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (medians_due.size() != 0) begin
			report_mismatch($sformatf("%0d beats never arrived", medians_due.size()));
			medians_due.delete();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		logic [CFG_DATA_W-1:0] data;
		data = value[CFG_DATA_W-1:0];
		settle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			width_reg = data[CFG_W_W-1:0];
		else
			height_reg = data[CFG_H_W-1:0];
	endtask

	// typed_n < 0: expectation comes from the predictor
	task automatic send_pixel(input pix_t value, input int typed_n, input filt_out_t t0,
			input filt_out_t t1);
		int        gap, n;
		filt_out_t got [2];
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= value;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
		n = filter_step(value, got);
		if (typed_n >= 0) begin
			n = typed_n;
			got[0] = t0;
			got[1] = t1;
		end
		for (int i = 0; i < n; i++)
			medians_due = {medians_due, got[i]};
	endtask

	task automatic random_frame(input frame_mode_t mode);
		int wv, hv, cut, sent, len, eff_w;
		case (mode)
			FR_EXTREME: begin
				wv = $urandom_range(1024, 2047);
				hv = $urandom_range(4096, 8191);
			end
			FR_BUSY: begin
				wv = $urandom_range(16, 40);
				hv = $urandom_range(6, 10);
			end
			default: begin
				case ($urandom_range(0, 9))
					0: wv = 0;
					1: wv = 1;
					2: wv = $urandom_range(9, 40);
					default: wv = $urandom_range(2, 8);
				endcase
				if ($urandom_range(0, 7) == 0)
					wv = wv | ($urandom_range(1, 3) << CFG_W_W);
				hv = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
			end
		endcase
		if (mode != FR_SMALL || $urandom_range(0, 4) != 0) begin
			write_reg(REG_FRAME_WIDTH, wv);
			write_reg(REG_FRAME_HEIGHT, hv);
		end
		len = clamp_dim(width_reg, MAXW) * (clamp_dim(height_reg, MAXH) + 1);
		// oversize frame: cut inside the first row and shrink; some small frames are cut too
		if (mode == FR_EXTREME)
			cut = $urandom_range(20, 60);
		else if (mode == FR_SMALL && $urandom_range(0, 3) == 0)
			cut = $urandom_range(1, len - 1);
		else
			cut = -1;
		tx_idle = (mode == FR_SMALL) && ($urandom_range(0, 3) != 0);
		rx_idle <= ($urandom_range(0, 3) != 0);
		if (mode == FR_BUSY)
			hold_req <= hold_req + 1;
		sent = 0;
		do begin
			if (sent == cut) begin
				// mid-frame: height may force the drain row, width only shrinks
				write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 4));
				if (mode == FR_EXTREME || $urandom_range(0, 1) == 1) begin
					eff_w = clamp_dim(width_reg, MAXW);
					write_reg(REG_FRAME_WIDTH, $urandom_range(0, (eff_w < 12) ? eff_w : 12));
				end
			end
			send_pixel(pick_pixel(), -1, NO_BEAT, NO_BEAT);
			sent++;
		end while (col_at != 0 || row_at != 0);
	endtask

	// receiver: random stall after each beat, one long hold on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			stall_left = LONG_HOLD;
		end else if (out_valid && !out_stall)
			stall_left = rx_idle ? $urandom_range(0, 4) : 0;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (medians_due.size() == 0)
				report_mismatch($sformatf("beat with nothing pending, median %0d", median));
			else begin
				due = medians_due.pop_front();
				if (median !== due.median)
					report_mismatch($sformatf("median %0d, want %0d", median, due.median));
				if (frame_end !== due.frame_end)
					report_mismatch($sformatf("frame_end %b, want %b", frame_end, due.frame_end));
				if (step_last !== due.step_last)
					report_mismatch($sformatf("step_last %b, want %b", step_last, due.step_last));
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("FAIL median_filter_3x3_top");
		$finish;
	end

	initial begin
		int          rand_pixels, mark, phase;
		frame_mode_t mode;

		// 1x1 frame: zero registers clamp to one
		add_row(ROW_CFG, REG_FRAME_WIDTH, 0, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_CFG, REG_FRAME_HEIGHT, 0, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 255, 0, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 'hAA, 1,
			'{median: '0, frame_end: 1'b1, step_last: 1'b1}, NO_BEAT);
		// 3x2 frame with extreme pixels; first row is silent
		add_row(ROW_CFG, REG_FRAME_WIDTH, 3, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_CFG, REG_FRAME_HEIGHT, 2, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 255, 0, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 0, 0, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 255, 0, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 0, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 255, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 0, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 'h55, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 'h55, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 'h55, -1, NO_BEAT, NO_BEAT);
		// 5x4 frame cut short by mid-frame writes
		add_row(ROW_CFG, REG_FRAME_WIDTH, 5, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_CFG, REG_FRAME_HEIGHT, 4, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 10, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 200, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 30, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 255, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 0, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 128, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 64, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_CFG, REG_FRAME_WIDTH, 1, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_PIX, '0, 99, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_CFG, REG_FRAME_HEIGHT, 1, -1, NO_BEAT, NO_BEAT);
		add_row(ROW_FINISH, '0, 0, -1, NO_BEAT, NO_BEAT);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 1'b1;
		rx_idle <= 1'b1;
		foreach (stim_rows[i]) begin
			case (stim_rows[i].kind)
				ROW_CFG: write_reg(stim_rows[i].index, stim_rows[i].value);
				ROW_PIX: send_pixel(pix_t'(stim_rows[i].value), stim_rows[i].typed_n,
					stim_rows[i].t0, stim_rows[i].t1);
				default: begin
					while (col_at != 0 || row_at != 0)
						send_pixel(pick_pixel(), -1, NO_BEAT, NO_BEAT);
				end
			endcase
		end

		rand_pixels = 0;
		phase = 0;
		while (rand_pixels < RANDOM_ITEMS) begin
			mode = (phase == 1) ? FR_EXTREME : ((phase == 2) ? FR_BUSY : FR_SMALL);
			mark = pixels_sent;
			random_frame(mode);
			rand_pixels += pixels_sent - mark;
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("PASS median_filter_3x3_top");
		else
			$display("FAIL median_filter_3x3_top");
		$finish;
	end

endmodule

@@ median_filter_3x3_top.f @@
rtl/medf3_pkg.sv
rtl/median_filter_3x3_top.sv
bench/tb_top.sv
